// ===== design/saa_pkg.sv =====
`timescale 1ns / 1ps

package saa_pkg;

  localparam int unsigned SQRT_W       = 64;
  localparam int unsigned SQRT_CELLS   = 32;
  localparam int unsigned DIV_CELLS    = 31;
  localparam int unsigned CORDIC_CELLS = 24;
  localparam int unsigned IDX_W        = 5;
  localparam int unsigned REM_W        = 33;
  localparam int unsigned DIVISOR_W    = 32;
  localparam int unsigned QUOT_W       = 31;
  localparam int unsigned XY_W         = 34;
  localparam int unsigned Z_W          = 33;

  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 33'sd1686629713;
  localparam logic signed [15:0]    ANGLE_MAX   = 16'sd25736;

  typedef struct packed {
    logic [SQRT_W-1:0] rem;
    logic [SQRT_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [REM_W-1:0]     rem;
    logic [DIVISOR_W-1:0] divisor;
    logic [QUOT_W-1:0]    quot;
  } divw_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_t;

  typedef struct packed {
    logic valid;
    logic degen;
    logic tneg;
  } meta_t;

  // arctan(2^-i) in Q.30
  function automatic logic signed [Z_W-1:0] atan_q30(input logic [IDX_W-1:0] idx);
    logic signed [Z_W-1:0] val;
    unique case (idx)
      5'd0:    val = 33'sd843314857;
      5'd1:    val = 33'sd497837829;
      5'd2:    val = 33'sd263043837;
      5'd3:    val = 33'sd133525159;
      5'd4:    val = 33'sd67021687;
      5'd5:    val = 33'sd33543516;
      5'd6:    val = 33'sd16775851;
      5'd7:    val = 33'sd8388437;
      5'd8:    val = 33'sd4194283;
      5'd9:    val = 33'sd2097149;
      default: val = 33'sd1 <<< (5'd30 - idx);
    endcase
    return val;
  endfunction

endpackage

// ===== design/saa_sqrt_cell.sv =====
`timescale 1ns / 1ps

module saa_sqrt_cell
  import saa_pkg::*;
(
  input  logic             clk_i,
  input  logic [IDX_W-1:0] idx_i,
  input  sqrt_t            cell_i,
  output sqrt_t            cell_o
);

  logic [SQRT_W-1:0] bit_w;
  logic [SQRT_W-1:0] trial;
  sqrt_t             cell_d;
  sqrt_t             cell_q;

  // one result bit per cell, weight 4^(31-idx)
  always_comb begin
    bit_w  = {{(SQRT_W-1){1'b0}}, 1'b1} << (6'(SQRT_W - 2) - {idx_i, 1'b0});
    trial  = cell_i.root + bit_w;
    cell_d = cell_i;
    if (cell_i.rem >= trial) begin
      cell_d.rem  = cell_i.rem - trial;
      cell_d.root = (cell_i.root >> 1) + bit_w;
    end else begin
      cell_d.root = cell_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule

// ===== design/saa_div_cell.sv =====
`timescale 1ns / 1ps

module saa_div_cell
  import saa_pkg::*;
(
  input  logic  clk_i,
  input  divw_t cell_i,
  output divw_t cell_o
);

  logic             ge;
  logic [REM_W-1:0] rem_n;
  divw_t            cell_d;
  divw_t            cell_q;

  // restoring step: one quotient bit, remainder doubled for the next cell
  always_comb begin
    ge     = cell_i.rem >= {1'b0, cell_i.divisor};
    rem_n  = ge ? cell_i.rem - {1'b0, cell_i.divisor} : cell_i.rem;
    cell_d.rem     = {rem_n[REM_W-2:0], 1'b0};
    cell_d.divisor = cell_i.divisor;
    cell_d.quot    = {cell_i.quot[QUOT_W-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule

// ===== design/saa_cordic_cell.sv =====
`timescale 1ns / 1ps

module saa_cordic_cell
  import saa_pkg::*;
(
  input  logic             clk_i,
  input  logic [IDX_W-1:0] idx_i,
  input  cordic_t          cell_i,
  output cordic_t          cell_o
);

  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  cordic_t                cell_d;
  cordic_t                cell_q;

  // vectoring: drive y towards zero, collect the angle in z
  always_comb begin
    xs = cell_i.x >>> idx_i;
    ys = cell_i.y >>> idx_i;
    if (cell_i.y > 0) begin
      cell_d.x = cell_i.x + ys;
      cell_d.y = cell_i.y - xs;
      cell_d.z = cell_i.z + atan_q30(idx_i);
    end else begin
      cell_d.x = cell_i.x - ys;
      cell_d.y = cell_i.y + xs;
      cell_d.z = cell_i.z - atan_q30(idx_i);
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule

// ===== design/signed_angle_about_axis_unit.sv =====
`timescale 1ns / 1ps

// the result strobe rises after a word has passed the front stages, the length square roots, the divider,
// the sine square root and the cordic, and the result is registered with it
// throughput: one word per cycle, set by the cell chains (three square roots, divider, cordic)
// busy is always low and results cannot be held off, so nothing ever stalls
// reset clears only the valid bits of the pipeline; no other state is kept
module signed_angle_about_axis_unit
  import saa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] from_x_i,
  input  logic signed [15:0] from_y_i,
  input  logic signed [15:0] from_z_i,
  input  logic signed [15:0] to_x_i,
  input  logic signed [15:0] to_y_i,
  input  logic signed [15:0] to_z_i,
  input  logic signed [15:0] axis_x_i,
  input  logic signed [15:0] axis_y_i,
  input  logic signed [15:0] axis_z_i,
  output logic               done_o,
  output logic signed [15:0] angle_o,
  output logic               degenerate_o
);

  localparam int unsigned META_DEPTH = 128;

  logic signed [15:0] fin [3];
  logic signed [15:0] tin [3];
  logic signed [15:0] nin [3];
  logic signed [31:0] pf  [3];
  logic signed [31:0] pt  [3];
  logic signed [33:0] df_d, dt_d;

  logic [5:1] v_q;

  // stage 1
  logic signed [15:0] f1_q [3];
  logic signed [15:0] t1_q [3];
  logic signed [15:0] n1_q [3];
  logic signed [33:0] df1_q, dt1_q;

  // stage 2
  logic signed [50:0] tv_full [3];
  logic signed [50:0] fw_full [3];
  logic signed [29:0] v2_q [3];
  logic signed [29:0] w2_q [3];
  logic signed [15:0] n2_q [3];

  // stage 3
  logic signed [59:0] sqv3_q [3];
  logic signed [59:0] sqw3_q [3];
  logic signed [59:0] pd3_q  [3];
  logic signed [59:0] cpa3_q [3];
  logic signed [59:0] cpb3_q [3];
  logic signed [15:0] n3_q   [3];

  // stage 4
  logic signed [61:0] vv_sum, ww_sum, dot_sum;
  logic [58:0]        vv4_q, ww4_q;
  logic signed [59:0] dot4_q;
  logic signed [59:0] cr4_q [3];
  logic signed [15:0] n4_q  [3];

  // stage 5
  logic signed [75:0] crn5_q [3];
  logic [58:0]        vv5_q, ww5_q;
  logic signed [59:0] dot5_q;

  // stage 6
  logic signed [77:0] trip;
  sqrt_t              sa6_q, sb6_q;
  logic signed [59:0] dot6_q;
  meta_t              meta_d;
  meta_t              meta_q [META_DEPTH];

  sqrt_t              sa_c [SQRT_CELLS+1];
  sqrt_t              sb_c [SQRT_CELLS+1];
  logic signed [59:0] dot_dly [SQRT_CELLS];

  // stages 7 to 10
  logic [59:0]        prod7_q, prod8_q;
  logic signed [59:0] dot7_q, dot8_q;
  logic [4:0]         k_d, k8_q;
  logic [31:0]        ps9_q;
  logic signed [59:0] ds9_q;
  logic signed [60:0] pext, dcl, dmag;
  divw_t              dv10_q;
  logic               dneg10_q;

  divw_t              dv_c [DIV_CELLS+1];
  logic               dneg_dly [DIV_CELLS];

  // stages 11 to 13
  logic signed [31:0] c11_q, c12_q, c13_q;
  logic [30:0]        cmag;
  logic [61:0]        c2_12_q;
  sqrt_t              sc13_q;

  sqrt_t              sc_c [SQRT_CELLS+1];
  logic signed [31:0] c_dly [SQRT_CELLS];

  // stage 14 and cordic
  cordic_t            co14_q;
  cordic_t            co_c [CORDIC_CELLS+1];
  logic signed [XY_W-1:0] s_ext;
  logic signed [XY_W-1:0] c_ext;

  // output
  logic signed [Z_W:0] zr;
  logic signed [16:0]  rr, rc;
  logic                done_q;
  logic signed [15:0]  angle_q;
  logic                degen_q;

  assign busy = 1'b0;

  assign fin[0] = from_x_i;
  assign fin[1] = from_y_i;
  assign fin[2] = from_z_i;
  assign tin[0] = to_x_i;
  assign tin[1] = to_y_i;
  assign tin[2] = to_z_i;
  assign nin[0] = axis_x_i;
  assign nin[1] = axis_y_i;
  assign nin[2] = axis_z_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pf[i] = fin[i] * nin[i];
      pt[i] = tin[i] * nin[i];
    end
    df_d = pf[0] + pf[1] + pf[2];
    dt_d = pt[0] + pt[1] + pt[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[4:1], start & ~busy};
    end
  end

  always_ff @(posedge clk_i) begin
    f1_q  <= fin;
    t1_q  <= tin;
    n1_q  <= nin;
    df1_q <= df_d;
    dt1_q <= dt_d;
  end

  // projection onto the plane, floored to Q.24
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tv_full[i] = $signed({t1_q[i], 28'b0}) - dt1_q * n1_q[i];
      fw_full[i] = $signed({f1_q[i], 28'b0}) - df1_q * n1_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      v2_q[i] <= tv_full[i][47:18];
      w2_q[i] <= fw_full[i][47:18];
    end
    n2_q <= n1_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sqv3_q[i] <= v2_q[i] * v2_q[i];
      sqw3_q[i] <= w2_q[i] * w2_q[i];
      pd3_q[i]  <= v2_q[i] * w2_q[i];
      cpa3_q[i] <= v2_q[(i+1)%3] * w2_q[(i+2)%3];
      cpb3_q[i] <= v2_q[(i+2)%3] * w2_q[(i+1)%3];
    end
    n3_q <= n2_q;
  end

  always_comb begin
    vv_sum  = sqv3_q[0] + sqv3_q[1] + sqv3_q[2];
    ww_sum  = sqw3_q[0] + sqw3_q[1] + sqw3_q[2];
    dot_sum = pd3_q[0] + pd3_q[1] + pd3_q[2];
  end

  always_ff @(posedge clk_i) begin
    vv4_q  <= vv_sum[58:0];
    ww4_q  <= ww_sum[58:0];
    dot4_q <= dot_sum[59:0];
    for (int i = 0; i < 3; i++) begin
      cr4_q[i] <= cpa3_q[i] - cpb3_q[i];
    end
    n4_q <= n3_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      crn5_q[i] <= cr4_q[i] * n4_q[i];
    end
    vv5_q  <= vv4_q;
    ww5_q  <= ww4_q;
    dot5_q <= dot4_q;
  end

  always_comb begin
    trip         = crn5_q[0] + crn5_q[1] + crn5_q[2];
    meta_d.valid = v_q[5];
    meta_d.degen = (vv5_q == '0) || (ww5_q == '0);
    meta_d.tneg  = trip < 0;
  end

  always_ff @(posedge clk_i) begin
    sa6_q.rem  <= {5'b0, vv5_q};
    sa6_q.root <= '0;
    sb6_q.rem  <= {5'b0, ww5_q};
    sb6_q.root <= '0;
    dot6_q     <= dot5_q;
  end

  // word status follows the data from stage 6 to the output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < META_DEPTH; i++) begin
        meta_q[i].valid <= 1'b0;
      end
    end else begin
      meta_q[0] <= meta_d;
      for (int i = 1; i < META_DEPTH; i++) begin
        meta_q[i] <= meta_q[i-1];
      end
    end
  end

  assign sa_c[0] = sa6_q;
  assign sb_c[0] = sb6_q;

  for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_len
    saa_sqrt_cell u_sqrt_v (
      .clk_i  (clk_i),
      .idx_i  (IDX_W'(i)),
      .cell_i (sa_c[i]),
      .cell_o (sa_c[i+1])
    );
    saa_sqrt_cell u_sqrt_w (
      .clk_i  (clk_i),
      .idx_i  (IDX_W'(i)),
      .cell_i (sb_c[i]),
      .cell_o (sb_c[i+1])
    );
  end

  always_ff @(posedge clk_i) begin
    dot_dly[0] <= dot6_q;
    for (int i = 1; i < SQRT_CELLS; i++) begin
      dot_dly[i] <= dot_dly[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    prod7_q <= sa_c[SQRT_CELLS].root[29:0] * sb_c[SQRT_CELLS].root[29:0];
    dot7_q  <= dot_dly[SQRT_CELLS-1];
  end

  // shift that brings the product below 2^32
  always_comb begin
    k_d = '0;
    for (int i = 32; i < 59; i++) begin
      if (prod7_q[i]) begin
        k_d = 5'(i - 31);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k8_q    <= k_d;
    prod8_q <= prod7_q;
    dot8_q  <= dot7_q;
  end

  always_ff @(posedge clk_i) begin
    ps9_q <= 32'(prod8_q >> k8_q);
    ds9_q <= dot8_q >>> k8_q;
  end

  always_comb begin
    pext = $signed({29'b0, ps9_q});
    if (ds9_q > pext) begin
      dcl = pext;
    end else if (ds9_q < -pext) begin
      dcl = -pext;
    end else begin
      dcl = ds9_q;
    end
    dmag = (dcl < 0) ? -dcl : dcl;
  end

  always_ff @(posedge clk_i) begin
    dv10_q.rem     <= {1'b0, dmag[31:0]};
    dv10_q.divisor <= ps9_q;
    dv10_q.quot    <= '0;
    dneg10_q       <= dcl < 0;
  end

  assign dv_c[0] = dv10_q;

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    saa_div_cell u_div (
      .clk_i  (clk_i),
      .cell_i (dv_c[i]),
      .cell_o (dv_c[i+1])
    );
  end

  always_ff @(posedge clk_i) begin
    dneg_dly[0] <= dneg10_q;
    for (int i = 1; i < DIV_CELLS; i++) begin
      dneg_dly[i] <= dneg_dly[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dneg_dly[DIV_CELLS-1]) begin
      c11_q <= -$signed({1'b0, dv_c[DIV_CELLS].quot});
    end else begin
      c11_q <= $signed({1'b0, dv_c[DIV_CELLS].quot});
    end
  end

  assign cmag = (c11_q < 0) ? 31'(-c11_q) : c11_q[30:0];

  always_ff @(posedge clk_i) begin
    c2_12_q <= cmag * cmag;
    c12_q   <= c11_q;
  end

  // sine from 1 - cos^2 in Q.60
  always_ff @(posedge clk_i) begin
    sc13_q.rem  <= {2'b0, (62'd1 << 60) - c2_12_q};
    sc13_q.root <= '0;
    c13_q       <= c12_q;
  end

  assign sc_c[0] = sc13_q;

  for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sin
    saa_sqrt_cell u_sqrt_s (
      .clk_i  (clk_i),
      .idx_i  (IDX_W'(i)),
      .cell_i (sc_c[i]),
      .cell_o (sc_c[i+1])
    );
  end

  always_ff @(posedge clk_i) begin
    c_dly[0] <= c13_q;
    for (int i = 1; i < SQRT_CELLS; i++) begin
      c_dly[i] <= c_dly[i-1];
    end
  end

  assign s_ext = $signed({3'b0, sc_c[SQRT_CELLS].root[30:0]});
  assign c_ext = c_dly[SQRT_CELLS-1];

  // negative cosine: start a quarter turn on
  always_ff @(posedge clk_i) begin
    if (c_ext < 0) begin
      co14_q.x <= s_ext;
      co14_q.y <= -c_ext;
      co14_q.z <= HALF_PI_Q30;
    end else begin
      co14_q.x <= c_ext;
      co14_q.y <= s_ext;
      co14_q.z <= '0;
    end
  end

  assign co_c[0] = co14_q;

  for (genvar i = 0; i < CORDIC_CELLS; i++) begin : g_cordic
    saa_cordic_cell u_cordic (
      .clk_i  (clk_i),
      .idx_i  (IDX_W'(i)),
      .cell_i (co_c[i]),
      .cell_o (co_c[i+1])
    );
  end

  always_comb begin
    zr = co_c[CORDIC_CELLS].z + (Z_W+1)'(1 << 16);
    rr = zr[Z_W:17];
    if (rr < 0) begin
      rc = '0;
    end else if (rr > ANGLE_MAX) begin
      rc = ANGLE_MAX;
    end else begin
      rc = rr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= meta_q[META_DEPTH-1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    degen_q <= meta_q[META_DEPTH-1].degen;
    if (meta_q[META_DEPTH-1].degen) begin
      angle_q <= '0;
    end else if (meta_q[META_DEPTH-1].tneg) begin
      angle_q <= 16'(-rc);
    end else begin
      angle_q <= rc[15:0];
    end
  end

  assign done_o       = done_q;
  assign angle_o      = angle_q;
  assign degenerate_o = degen_q;

  a_degen_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && degenerate_o |-> angle_o == 16'sd0)
    else $error("degenerate word with nonzero angle");

  a_angle_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (angle_o <= ANGLE_MAX) && (angle_o >= -ANGLE_MAX))
    else $error("angle outside minus pi to pi");

  a_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    meta_q[META_DEPTH-1].valid |=> done_o)
    else $error("word lost at the output stage");

endmodule
